/* sv/wgm_pkg.sv */
// Shared types and constants for the wildcard glob matcher.
// Item structs, operation codes and pattern symbol codes; no dependencies.
`default_nettype none

package wgm_pkg;

  // pattern store depth and derived widths
  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned SLOT_W      = $clog2(PATTERN_MAX);
  localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned SYM_W       = 8;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [SYM_W-1:0]  sym_t;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TEXT  = 2'd2;

  // wildcard symbols
  localparam sym_t SYM_ONE = 8'h3F;
  localparam sym_t SYM_ANY = 8'h2A;

  // input item
  typedef struct packed {
    logic [1:0] operation;
    slot_t      pattern_slot;
    sym_t       symbol;
  } in_item_t;

  // result item
  typedef struct packed {
    logic matched;
    logic all_dead;
  } out_item_t;

  // control from the top level to the row of cells
  typedef struct packed {
    logic  start;
    logic  step;
    logic  wr;
    slot_t slot;
    sym_t  sym;
  } row_ctl_t;

  // control broadcast to every cell
  typedef struct packed {
    logic start;
    logic step;
    sym_t sym;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/wgm_cell.sv */
// One pattern position of the matcher: holds its pattern byte and active bit.
// Passes closure and advance bits to the next cell; uses wgm_pkg.
`default_nettype none

module wgm_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               seed,      // position zero: reset value and start seed
  input  wgm_pkg::cell_ctl_t ctl,
  input  wire               wr_en,
  input  wire               pos_live,  // position at or below pattern length
  input  wire               tr_live,   // position below pattern length
  input  wire               pre_cin,
  input  wire               post_cin,
  input  wire               adv_in,
  output logic              pre_cout,
  output logic              post_cout,
  output logic              adv_out,
  output logic              post_out,
  output logic              act_out
);

  wgm_pkg::sym_t byte_r;
  logic          act_r;
  logic          act_nxt;
  logic          is_star;
  logic          hit;
  logic          pre_act;
  logic          base;

  // pattern byte decode
  assign is_star = (byte_r == wgm_pkg::SYM_ANY);
  assign hit     = is_star || (byte_r == wgm_pkg::SYM_ONE) || (byte_r == ctl.sym);

  // closure of the held set before the text byte
  assign pre_act  = (act_r & pos_live) | pre_cin;
  assign pre_cout = pre_act & is_star & tr_live;

  // advance on the text byte
  assign adv_out = pre_act & tr_live & hit;

  // new set, then its closure
  assign base      = ctl.start ? seed : (adv_in | pre_cout);
  assign post_out  = base | post_cin;
  assign post_cout = post_out & is_star & tr_live;

  assign act_nxt = (ctl.start || ctl.step) ? post_out : act_r;
  assign act_out = act_r;

  // active bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= seed;
    end else begin
      act_r <= act_nxt;
    end
  end

  // pattern byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_r <= ctl.sym;
    end
  end

endmodule

`default_nettype wire

/* sv/wgm_row.sv */
// Row of pattern cells plus the end position, and the match report.
// Uses wgm_pkg and wgm_cell.
`default_nettype none

module wgm_row (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wgm_pkg::row_ctl_t   ctl,
  input  wgm_pkg::len_t       len,
  output wgm_pkg::out_item_t  res
);

  localparam int unsigned N = wgm_pkg::PATTERN_MAX;

  wgm_pkg::cell_ctl_t cctl;
  logic [N:0]         pre_c;
  logic [N:0]         post_c;
  logic [N:0]         adv;
  logic [N:0]         post_vec;
  logic [N:0]         act_vec;
  logic               tail_act_r;
  logic               tail_act_nxt;

  assign cctl.start = ctl.start;
  assign cctl.step  = ctl.step;
  assign cctl.sym   = ctl.sym;

  assign pre_c[0]  = 1'b0;
  assign post_c[0] = 1'b0;
  assign adv[0]    = 1'b0;

  // one cell per pattern position
  for (genvar g = 0; g < N; g++) begin : g_cell
    wgm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .seed      (g == 0),
      .ctl       (cctl),
      .wr_en     (ctl.wr && (ctl.slot == wgm_pkg::slot_t'(g))),
      .pos_live  (wgm_pkg::len_t'(g) <= len),
      .tr_live   (wgm_pkg::len_t'(g) < len),
      .pre_cin   (pre_c[g]),
      .post_cin  (post_c[g]),
      .adv_in    (adv[g]),
      .pre_cout  (pre_c[g+1]),
      .post_cout (post_c[g+1]),
      .adv_out   (adv[g+1]),
      .post_out  (post_vec[g]),
      .act_out   (act_vec[g])
    );
  end

  // end position: no pattern byte, only reached from below
  assign post_vec[N]  = (ctl.start ? 1'b0 : adv[N]) | post_c[N];
  assign tail_act_nxt = (ctl.start || ctl.step) ? post_vec[N] : tail_act_r;
  assign act_vec[N]   = tail_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_act_r <= 1'b0;
    end else begin
      tail_act_r <= tail_act_nxt;
    end
  end

  // report on the new set
  assign res.matched  = post_vec[len];
  assign res.all_dead = ~|post_vec;

  // a start always leaves position zero active
  a_start_seed: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> act_vec[0])
    else $error("position zero not active after start");

  // a dead set stays dead on text bytes
  a_dead_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && !ctl.start && (act_vec == '0)) |=> (act_vec == '0))
    else $error("dead set revived by a text byte");

  // a match and an empty set never coincide
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.start || ctl.step) |-> !(res.matched && res.all_dead))
    else $error("match reported with no active position");

endmodule

`default_nettype wire

/* sv/wgm_outbuf.sv */
// Output register with a skid stage for the result channel.
// Uses wgm_pkg for the result item type.
`default_nettype none

module wgm_outbuf (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 res_valid,
  input  wgm_pkg::out_item_t  res,
  output logic                full,
  output logic                out_valid,
  input  wire                 out_stall,
  output wgm_pkg::out_item_t  out_data
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  wgm_pkg::out_item_t  out_data_r;
  wgm_pkg::out_item_t  out_data_nxt;
  logic                skid_valid_r;
  logic                skid_valid_nxt;
  wgm_pkg::out_item_t  skid_data_r;
  wgm_pkg::out_item_t  skid_data_nxt;
  logic                out_take;

  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

  // buffer steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // skid stage only fills behind a held output
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full with output register empty");

  // no new item arrives while the skid stage is full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_valid)
    else $error("result arrived with buffer full");

endmodule

`default_nettype wire

/* sv/wildcard_glob_matcher_top.sv */
// Top level of the wildcard glob matcher: handshakes, length register.
// Uses wgm_pkg, wgm_row and wgm_outbuf.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries items of three kinds:
//   write a pattern byte into a slot, start a new text, or one text byte.
//   '?' in the pattern matches any one byte, '*' any run of bytes.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data) sets the pattern
//   length; cfg_ready is always high, and a length above 64 acts as 64.
//   Each start and text item gives one result (matched, all_dead) on the
//   output channel (out_valid, out_stall, out_data); writes give none.
//   Results: each result is registered in the output register, or in the skid
//   entry if the output is held. Throughput: one item per cycle while in_stall
//   is low; all 64 cells update at once, the '*' closure rippling through them.
//   Stall: results wait in an output register and one skid entry; in_stall
//   rises only when both are full, and drops once the receiver takes one.
//   Reset: the pattern length is zero and only position zero is active, so
//   a text byte before any start behaves as if a start had come. Pattern
//   bytes are not cleared and must be written before use.
`default_nettype none

module wildcard_glob_matcher_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wgm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output wgm_pkg::out_item_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wgm_pkg::len_t       cfg_data
);

  wgm_pkg::len_t      len_r;
  wgm_pkg::len_t      len_nxt;
  wgm_pkg::len_t      len_use;
  wgm_pkg::row_ctl_t  row_ctl;
  wgm_pkg::out_item_t res;
  logic               in_acc;
  logic               buf_full;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & ~in_stall;
  assign in_stall  = buf_full;

  // length register
  assign len_nxt = (cfg_valid && cfg_ready) ? cfg_data : len_r;
  assign len_use = (len_r > wgm_pkg::len_t'(wgm_pkg::PATTERN_MAX))
                   ? wgm_pkg::len_t'(wgm_pkg::PATTERN_MAX) : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // operation decode
  always_comb begin
    row_ctl.start = 1'b0;
    row_ctl.step  = 1'b0;
    row_ctl.wr    = 1'b0;
    row_ctl.slot  = in_data.pattern_slot;
    row_ctl.sym   = in_data.symbol;
    case (in_data.operation)
      wgm_pkg::OP_WRITE: row_ctl.wr    = in_acc;
      wgm_pkg::OP_START: row_ctl.start = in_acc;
      wgm_pkg::OP_TEXT:  row_ctl.step  = in_acc;
      default: ;
    endcase
  end

  // cell row
  wgm_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (row_ctl),
    .len   (len_use),
    .res   (res)
  );

  // result buffering
  wgm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (row_ctl.start | row_ctl.step),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* verif/tb_wildcard_glob_matcher_top.sv */
// Testbench for the wildcard glob matcher top level: pattern writes, starts and text bytes.
// A local position-set predictor checks every result. Handshakes idle at random on both sides.
// Depends on wgm_pkg and wildcard_glob_matcher_top.

module tb_wildcard_glob_matcher_top;

  // unused operation code, ignored by the block
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned CALM_FROM = 900;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  wgm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wgm_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  wgm_pkg::len_t      cfg_data = '0;

  wildcard_glob_matcher_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted state of the matcher
  logic [wgm_pkg::PATTERN_MAX:0] live_pos = {{wgm_pkg::PATTERN_MAX{1'b0}}, 1'b1};
  wgm_pkg::sym_t                 pat_mem [wgm_pkg::PATTERN_MAX];
  wgm_pkg::len_t                 pat_len = '0;

  // items waiting to be offered, verdicts waiting to arrive
  wgm_pkg::in_item_t  pending_items [$];
  wgm_pkg::out_item_t verdict_q [$];
  wgm_pkg::sym_t      plan_pat [wgm_pkg::PATTERN_MAX];

  bit          idle_en = 1'b1;
  bit          stall_en = 1'b1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_accepted = 0;
  int unsigned n_queued = 0;
  int unsigned n_settings = 0;

  // length in use, saturated at the store depth
  function automatic int unsigned used_len();
    if (int'(pat_len) > wgm_pkg::PATTERN_MAX) return wgm_pkg::PATTERN_MAX;
    return int'(pat_len);
  endfunction

  // drop positions above the length, then ripple the star closure upward
  function automatic void close_live(input int unsigned n);
    for (int unsigned i = n + 1; i <= wgm_pkg::PATTERN_MAX; i++) live_pos[i] = 1'b0;
    for (int unsigned i = 0; i < n; i++)
      if (live_pos[i] && pat_mem[i] == wgm_pkg::SYM_ANY) live_pos[i+1] = 1'b1;
  endfunction

  // advance the position set by one item; returns 1 when a verdict follows
  function automatic bit glob_advance(input wgm_pkg::in_item_t it,
                                      output wgm_pkg::out_item_t verdict);
    int unsigned                   n;
    logic [wgm_pkg::PATTERN_MAX:0] nxt;
    n = used_len();
    verdict = '0;
    case (it.operation)
      wgm_pkg::OP_WRITE: begin
        pat_mem[it.pattern_slot] = it.symbol;
        return 1'b0;
      end
      wgm_pkg::OP_START: begin
        live_pos = '0;
        live_pos[0] = 1'b1;
        close_live(n);
      end
      wgm_pkg::OP_TEXT: begin
        close_live(n);
        nxt = '0;
        for (int unsigned i = 0; i < n; i++) begin
          if (live_pos[i]) begin
            if (pat_mem[i] == wgm_pkg::SYM_ANY) begin
              nxt[i] = 1'b1;
              nxt[i+1] = 1'b1;
            end else if (pat_mem[i] == wgm_pkg::SYM_ONE || pat_mem[i] == it.symbol) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        live_pos = nxt;
        close_live(n);
      end
      default: return 1'b0;
    endcase
    verdict.matched = live_pos[n];
    verdict.all_dead = ~|live_pos;
    return 1'b1;
  endfunction

  // sender: predict each accepted item, then offer the next one or idle
  always @(posedge clk) begin : drive
    wgm_pkg::out_item_t v;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pat_len = cfg_data;
      if (in_valid && !in_stall) begin
        n_accepted++;
        if (glob_advance(in_data, v)) verdict_q.push_back(v);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_en && pending_items.size() > 0 && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted result against the oldest verdict
  always @(posedge clk) begin : receive
    wgm_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual matched %0b all_dead %0b",
                   $time, out_data.matched, out_data.all_dead);
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          if (out_data.matched !== want.matched) begin
            n_errors++;
            $display("%0t: matched mismatch, expected %0b actual %0b",
                     $time, want.matched, out_data.matched);
          end
          if (out_data.all_dead !== want.all_dead) begin
            n_errors++;
            $display("%0t: all_dead mismatch, expected %0b actual %0b",
                     $time, want.all_dead, out_data.all_dead);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_en && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] op, input wgm_pkg::slot_t slot,
                            input wgm_pkg::sym_t sym);
    wgm_pkg::in_item_t it;
    it.operation = op;
    it.pattern_slot = slot;
    it.symbol = sym;
    pending_items.push_back(it);
    if (op != OP_NONE) n_queued++;
    if (op == wgm_pkg::OP_WRITE) plan_pat[slot] = sym;
  endtask

  // pattern bytes weighted towards wildcards and a tiny alphabet
  function automatic wgm_pkg::sym_t pattern_symbol();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return wgm_pkg::SYM_ANY;
    if (r < 5) return wgm_pkg::SYM_ONE;
    if (r < 9) return wgm_pkg::sym_t'(8'h61 + $urandom_range(0, 2));
    return wgm_pkg::sym_t'($urandom);
  endfunction

  // text bytes mostly from 'a'..'c', now and then any byte
  function automatic wgm_pkg::sym_t text_letter();
    if ($urandom_range(0, 9) == 0) return wgm_pkg::sym_t'($urandom);
    return wgm_pkg::sym_t'(8'h61 + $urandom_range(0, 2));
  endfunction

  task automatic queue_noise();
    case ($urandom_range(0, 3))
      0: queue_item(OP_NONE, wgm_pkg::slot_t'($urandom), wgm_pkg::sym_t'($urandom));
      1: queue_item(wgm_pkg::OP_TEXT, wgm_pkg::slot_t'($urandom), wgm_pkg::sym_t'($urandom));
      2: queue_item(wgm_pkg::OP_START, wgm_pkg::slot_t'($urandom), wgm_pkg::sym_t'($urandom));
      default: queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'($urandom), pattern_symbol());
    endcase
  endtask

  // a text built by expanding the planned pattern, sometimes spoilt
  task automatic queue_text(input int unsigned n, input bit with_start);
    wgm_pkg::sym_t txt [$];
    if (with_start)
      queue_item(wgm_pkg::OP_START, wgm_pkg::slot_t'($urandom), wgm_pkg::sym_t'($urandom));
    for (int unsigned j = 0; j < n; j++) begin
      case (plan_pat[j])
        wgm_pkg::SYM_ANY: repeat ($urandom_range(0, 3)) txt.push_back(text_letter());
        wgm_pkg::SYM_ONE: txt.push_back(wgm_pkg::sym_t'($urandom));
        default: txt.push_back(plan_pat[j]);
      endcase
    end
    if (txt.size() > 0 && $urandom_range(0, 2) == 0)
      txt[$urandom_range(0, txt.size() - 1)] = text_letter();
    if ($urandom_range(0, 5) == 0) txt.push_back(text_letter());
    foreach (txt[i]) begin
      if ($urandom_range(0, 15) == 0) queue_noise();
      queue_item(wgm_pkg::OP_TEXT, wgm_pkg::slot_t'($urandom), txt[i]);
    end
  endtask

  // wait until every item is in and every verdict out, then let the pipe settle
  task automatic drain_block();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_length(input wgm_pkg::len_t v);
    drain_block();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    int unsigned plen;
    int unsigned eff;
    int unsigned n_texts;
    int unsigned r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero length after reset, text byte before any start
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h00);
    queue_item(wgm_pkg::OP_START, '1, 8'hFF);
    queue_item(wgm_pkg::OP_TEXT, '1, 8'hFF);
    queue_item(OP_NONE, '1, 8'hFF);

    // every slot written before any nonzero length
    for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++)
      queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'(i), wgm_pkg::SYM_ANY);

    // full length all-star pattern, then a length beyond the store
    write_length(wgm_pkg::len_t'(wgm_pkg::PATTERN_MAX));
    queue_item(wgm_pkg::OP_START, '0, '0);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h5A);
    write_length(wgm_pkg::len_t'(7'h7F));
    queue_item(wgm_pkg::OP_START, '1, '1);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'hFF);

    // "a?*c": literal, any one byte, any run, literal
    queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'(0), 8'h61);
    queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'(1), wgm_pkg::SYM_ONE);
    queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'(3), 8'h63);
    write_length(wgm_pkg::len_t'(4));
    queue_item(wgm_pkg::OP_START, '0, '0);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h61);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h78);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h79);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h63);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h64);
    queue_item(wgm_pkg::OP_START, '0, '0);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h62);

    // literal 0xFF and 0x00 at the tail of the pattern
    queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'(4), 8'hFF);
    queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'(5), 8'h00);
    write_length(wgm_pkg::len_t'(6));
    queue_item(wgm_pkg::OP_START, '0, '0);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h61);
    queue_item(wgm_pkg::OP_TEXT, '0, wgm_pkg::SYM_ONE);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h63);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'hFF);
    queue_item(wgm_pkg::OP_TEXT, '0, 8'h00);

    // random phases, one length setting each; calm handshakes near the end
    while (n_queued < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r == 0) plen = wgm_pkg::PATTERN_MAX;
      else if (r == 1) plen = $urandom_range(wgm_pkg::PATTERN_MAX + 1, 127);
      else if (r == 2) plen = 0;
      else plen = $urandom_range(1, 10);
      if (n_queued >= CALM_FROM) begin
        idle_en = 1'b0;
        stall_en = 1'b0;
      end else begin
        idle_en = ($urandom_range(0, 3) != 0);
        stall_en = ($urandom_range(0, 3) != 0);
      end
      write_length(wgm_pkg::len_t'(plen));
      eff = (plen > wgm_pkg::PATTERN_MAX) ? wgm_pkg::PATTERN_MAX : plen;
      if (eff <= 16 || $urandom_range(0, 1) == 0)
        for (int i = 0; i < eff; i++)
          queue_item(wgm_pkg::OP_WRITE, wgm_pkg::slot_t'(i), pattern_symbol());
      n_texts = $urandom_range(2, 5);
      // the first text may run on from the old length without a start
      for (int t = 0; t < n_texts && n_queued < ITEM_TARGET; t++)
        queue_text(eff, (t != 0) || ($urandom_range(0, 3) != 0));
    end

    drain_block();
    $display("ran %0d items through %0d length settings, %0d verdicts checked",
             n_accepted, n_settings, n_checked);
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* wildcard_glob_matcher_top.f */
sv/wgm_pkg.sv
sv/wgm_cell.sv
sv/wgm_row.sv
sv/wgm_outbuf.sv
sv/wildcard_glob_matcher_top.sv
verif/tb_wildcard_glob_matcher_top.sv
